// File: src/nfa_pkg.sv
// ----------------------------------------------------------------------------
// nfa_pkg: shared definitions of the NFA string matcher
// Field widths, item modes, register indexes, the wildcard label and the
// command that the top level broadcasts to every state cell.
// ----------------------------------------------------------------------------
package nfa_pkg;

  // Number of automaton states that the node fields can address.
  localparam int unsigned STATES = 8;

  // Fixed field widths.
  localparam int unsigned MODE_W = 2;
  localparam int unsigned NODE_W = 3;
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned CFG_W  = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // The label that matches any symbol.
  localparam logic [SYM_W-1:0] ANY_LABEL = 8'h2E;

  // Item modes. Code three means nothing and is ignored.
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_SYM  = 2'd1,
    MODE_END  = 2'd2
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEPT = 1'd0,
    CFG_START  = 1'd1
  } cfg_idx_e;

  // Command broadcast to every cell of the chain for one accepted item.
  typedef struct packed {
    logic              load;     // write one edge label
    logic              advance;  // consume a symbol
    logic              clear;    // end of string
    logic              fresh;    // no symbol of this string consumed yet
    logic [NODE_W-1:0] start;    // start state of the string
    logic [NODE_W-1:0] from;     // source state of a load
    logic [NODE_W-1:0] to;       // destination state of a load
    logic [SYM_W-1:0]  symbol;   // label to write or symbol to consume
  } cell_cmd_t;

endpackage

// File: src/nfa_cell.sv
// ----------------------------------------------------------------------------
// nfa_cell: one state of the automaton
// Holds the outgoing edge labels of its state and its active bit. It adds
// its reachable successors to the set handed on from the previous cell and
// its accept hit to the running match flag.
// ----------------------------------------------------------------------------
module nfa_cell #(
  parameter int unsigned States = nfa_pkg::STATES,
  parameter int unsigned Index  = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nfa_pkg::cell_cmd_t  cmd_i,
  input  logic                accept_i,
  input  logic [States-1:0]   reach_i,
  input  logic                hit_i,
  input  logic                next_i,
  output logic [States-1:0]   reach_o,
  output logic                hit_o,
  output logic                active_o
);
  import nfa_pkg::*;

  localparam int unsigned ToW = (States > 1) ? $clog2(States) : 1;

  logic [SYM_W-1:0]  label_q [States];
  logic              active_q;
  logic              active_d;
  logic              row_sel;
  logic              cur;
  logic [States-1:0] hits;

  // A load addressed to this state's row.
  assign row_sel = cmd_i.load && (cmd_i.from == NODE_W'(Index));

  // Edge label row; the top level only issues loads with the target in range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < int'(States); t++) begin
        label_q[t] <= '0;
      end
    end else if (row_sel) begin
      label_q[cmd_i.to[ToW-1:0]] <= cmd_i.symbol;
    end
  end

  // Active bit: takes the chain result on a symbol, clears at end of string.
  always_comb begin
    active_d = active_q;
    if (cmd_i.clear) begin
      active_d = 1'b0;
    end else if (cmd_i.advance) begin
      active_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  // While the string is fresh, only the start state counts as active.
  assign cur = cmd_i.fresh ? (cmd_i.start == NODE_W'(Index)) : active_q;

  // Successors reached over a matching, present edge.
  always_comb begin
    for (int t = 0; t < int'(States); t++) begin
      hits[t] = cur && (label_q[t] != '0) &&
                ((label_q[t] == cmd_i.symbol) || (label_q[t] == ANY_LABEL));
    end
  end

  // Accumulate along the chain.
  assign reach_o  = reach_i | hits;
  assign hit_o    = hit_i | (cur & accept_i);
  assign active_o = active_q;

endmodule

// File: src/nfa_wildcard_string_matcher.sv
// ----------------------------------------------------------------------------
// nfa_wildcard_string_matcher: NFA matcher with wildcard edge labels
// Loads an edge label table, runs strings through the automaton one symbol
// per cycle over a chain of state cells, and reports a match per string.
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_stall_o    mode, from_node, to_node, symbol
//   out       output     out_valid_o / out_stall_i  matched
//   cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One item is accepted per cycle while the input is not stalled; a symbol settles through the cell chain
// in the cycle it is accepted, and an end item's result appears in the
// output register on the next cycle.
// Reset clears the edge table, the active set and all registers but the held match flag; a string
// then starts fresh from the start state.
// The input stalls only for an end item while a previous result is still
// held by a stalled output; loads and symbols are taken meanwhile.
// ----------------------------------------------------------------------------
module nfa_wildcard_string_matcher #(
  parameter int unsigned STATES = nfa_pkg::STATES  // 2 to 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [nfa_pkg::MODE_W-1:0]    in_mode_i,
  input  logic [nfa_pkg::NODE_W-1:0]    in_from_node_i,
  input  logic [nfa_pkg::NODE_W-1:0]    in_to_node_i,
  input  logic [nfa_pkg::SYM_W-1:0]     in_symbol_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          out_matched_o,
  input  logic                          cfg_we_i,
  input  logic [nfa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [nfa_pkg::CFG_W-1:0]     cfg_data_i
);
  import nfa_pkg::*;

  logic [CFG_W-1:0]  accept_q;
  logic [NODE_W-1:0] start_q;
  logic              fresh_q;
  logic              fresh_d;
  logic              out_valid_q;
  logic              out_valid_d;
  logic              matched_q;
  logic              in_acc;
  logic              load_ok;
  mode_e             mode;
  cell_cmd_t         cmd;

  logic [STATES-1:0] reach_c [STATES+1];
  logic [STATES:0]   hit_c;
  logic [STATES-1:0] next_set;
  logic [STATES-1:0] active_set;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accept_q <= '0;
      start_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ACCEPT: accept_q <= cfg_data_i;
        CFG_START:  start_q  <= cfg_data_i[NODE_W-1:0];
        default:    ;
      endcase
    end
  end

  // Input handshake: only an end item needs room in the output register.
  assign mode       = mode_e'(in_mode_i);
  assign in_stall_o = out_valid_q && out_stall_i && (mode == MODE_END);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Loads naming a state beyond the automaton are dropped.
  assign load_ok = ({1'b0, in_from_node_i} < (NODE_W+1)'(STATES)) &&
                   ({1'b0, in_to_node_i} < (NODE_W+1)'(STATES));

  // Command broadcast to the cells.
  always_comb begin
    cmd         = '0;
    cmd.fresh   = fresh_q;
    cmd.start   = start_q;
    cmd.from    = in_from_node_i;
    cmd.to      = in_to_node_i;
    cmd.symbol  = in_symbol_i;
    case (mode)
      MODE_LOAD: cmd.load    = in_acc && load_ok;
      MODE_SYM:  cmd.advance = in_acc;
      MODE_END:  cmd.clear   = in_acc;
      default:   ;
    endcase
  end

  // Chain of state cells; the set and the match flag ripple through it.
  assign reach_c[0] = '0;
  assign hit_c[0]   = 1'b0;

  for (genvar i = 0; i < STATES; i++) begin : g_cell
    nfa_cell #(
      .States (STATES),
      .Index  (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .accept_i (accept_q[i]),
      .reach_i  (reach_c[i]),
      .hit_i    (hit_c[i]),
      .next_i   (next_set[i]),
      .reach_o  (reach_c[i+1]),
      .hit_o    (hit_c[i+1]),
      .active_o (active_set[i])
    );
  end

  assign next_set = reach_c[STATES];

  // Fresh flag: cleared by the first symbol, set again at end of string.
  always_comb begin
    fresh_d = fresh_q;
    if (cmd.clear) begin
      fresh_d = 1'b1;
    end else if (cmd.advance) begin
      fresh_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
    end else begin
      fresh_q <= fresh_d;
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.clear) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.clear) begin
      matched_q <= hit_c[STATES];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_matched_o = matched_q;

  // Assertions.

  // The input is held back only for a result waiting at a stalled output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a pending result");

  // An end item leaves a fresh string with an empty active set behind.
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (mode == MODE_END)) |=> (fresh_q && (active_set == '0)))
    else $error("string state not reset after end item");

  // An end item's match flag reaches the output register.
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (mode == MODE_END)) |=>
      (out_valid_o && (out_matched_o == $past(hit_c[STATES]))))
    else $error("end item result lost");

  // A held result does not change while other items are taken.
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_matched_o)))
    else $error("stalled result changed");

endmodule
